>>> hdl/c8x_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared constants, types and helpers of the instruction execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int SD_W        = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] KIND_DONE  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_DRAW  = 2'd3;

   localparam logic [1:0] CSR_COMPAT = 2'd0;
   localparam logic [1:0] CSR_START  = 2'd1;
   localparam logic [1:0] CSR_FONT   = 2'd2;

   // Controller to datapath commands.
   typedef struct packed {
      logic       load;      // capture the input transfer
      logic       execute;   // commit register effects of the opcode
      logic       emit;      // load the output register
      logic [3:0] seq;       // memory-write sequence number
      logic       final_out; // emit the closing step-done result
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [4:0] writes;    // number of memory-write results
      logic       extra;     // clear or draw result precedes step-done
      logic       out_busy;  // output register holds an untaken result
   } status_type;

   // Decimal digits of a byte, found by compare and subtract.
   function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] d);
      logic [7:0] r;
      logic [7:0] h, rem, t, o;
      begin
         if (v >= 8'd200) begin
            h   = 8'd2;
            rem = v - 8'd200;
         end else if (v >= 8'd100) begin
            h   = 8'd1;
            rem = v - 8'd100;
         end else begin
            h   = 8'd0;
            rem = v;
         end
         t = 8'd0;
         for (int i = 1; i < 10; i++) begin
            if (rem >= 8'(i * 10)) t = 8'(i);
         end
         o = rem - t * 8'd10;
         case (d)
            2'd0:    r = h;
            2'd1:    r = t;
            default: r = o;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

>>> hdl/chip8_instruction_execute_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_execute_unit
// Executes one fetched CHIP-8 opcode per transfer and reports its results.
// ----------------------------------------------------------------------------
// Each accepted opcode is captured, the return stack is read in the next
// cycle, and then the result items are emitted one per cycle, unless the
// receiver stalls, through the output register: memory writes for the BCD
// and register-store opcodes, a clear or draw request where the opcode asks
// for one, and finally a step-done item with last set. Further input is held
// off until the final item has been loaded into the output register.
// Register, pc, stack and timer updates commit together with the final item.
// The return stack is a small RAM; call overflow and return underflow set
// stack_error and leave the state unchanged apart from the pc advancing by two.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_instruction,
   input  wire logic [15:0] req_keys_down,
   input  wire logic        req_key_event_valid,
   input  wire logic [3:0]  req_key_event_code,
   input  wire logic [7:0]  req_random_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [11:0]      rsp_write_address,
   output logic [7:0]       rsp_write_data,
   output logic [11:0]      rsp_next_pc,
   output logic [11:0]      rsp_index_out,
   output logic [7:0]       rsp_draw_x,
   output logic [7:0]       rsp_draw_y,
   output logic [3:0]       rsp_draw_rows,
   output logic             rsp_stack_error,
   output logic             rsp_last
);
   import c8x_pkg::*;

   cmd_type    cmd;
   status_type status;

   c8x_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   c8x_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_instruction     (req_instruction),
      .req_keys_down       (req_keys_down),
      .req_key_event_valid (req_key_event_valid),
      .req_key_event_code  (req_key_event_code),
      .req_random_byte     (req_random_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_write_address   (rsp_write_address),
      .rsp_write_data      (rsp_write_data),
      .rsp_next_pc         (rsp_next_pc),
      .rsp_index_out       (rsp_index_out),
      .rsp_draw_x          (rsp_draw_x),
      .rsp_draw_y          (rsp_draw_y),
      .rsp_draw_rows       (rsp_draw_rows),
      .rsp_stack_error     (rsp_stack_error),
      .rsp_last            (rsp_last)
   );
endmodule
`default_nettype wire

>>> hdl/c8x_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module c8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

>>> hdl/c8x_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_ctrl
// Sequencer: capture, then emit the result items one by one; register effects commit with the last.
// ----------------------------------------------------------------------------
module c8x_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire c8x_pkg::status_type  status,
   output c8x_pkg::cmd_type          cmd
);
   import c8x_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;   // results already emitted

   logic [4:0] total;
   assign total = status.writes + 5'(status.extra);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_stall = (state_ff != ST_IDLE);
      cmd       = '0;
      cmd.seq   = cnt_ff[3:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_EMIT;
            cnt_in   = '0;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               if (cnt_ff == total) begin
                  // Closing result; register effects commit with it.
                  cmd.final_out = 1'b1;
                  cmd.execute   = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 5'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule
`default_nettype wire

>>> hdl/c8x_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_datapath
// Register file, index, pc, stack, timers and the output register.
// ----------------------------------------------------------------------------
module c8x_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire c8x_pkg::cmd_type    cmd,
   output c8x_pkg::status_type      status,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [11:0]         csr_data,
   input  wire logic [15:0]         req_instruction,
   input  wire logic [15:0]         req_keys_down,
   input  wire logic                req_key_event_valid,
   input  wire logic [3:0]          req_key_event_code,
   input  wire logic [7:0]          req_random_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [11:0]              rsp_write_address,
   output logic [7:0]               rsp_write_data,
   output logic [11:0]              rsp_next_pc,
   output logic [11:0]              rsp_index_out,
   output logic [7:0]               rsp_draw_x,
   output logic [7:0]               rsp_draw_y,
   output logic [3:0]               rsp_draw_rows,
   output logic                     rsp_stack_error,
   output logic                     rsp_last
);
   import c8x_pkg::*;

   logic             compat_ff;
   logic [11:0]      font_ff;
   logic [7:0]       v_ff [16];
   logic [11:0]      idx_ff, pc_ff;
   logic [SD_W-1:0]  sd_ff;
   logic [7:0]       delay_ff, sound_ff;
   logic [15:0]      op_ff;
   logic [15:0]      keys_ff;
   logic             kv_ff;
   logic [3:0]       kc_ff;
   logic [7:0]       rnd_ff;

   // Return stack memory: one address per opcode, read at the top on return.
   logic             stk_we;
   logic [SP_W-1:0]  stk_addr;
   logic [11:0]      stk_rd;

   logic [3:0]  x, y, n;
   logic [7:0]  nn, vx, vy;
   logic [11:0] nnn;
   assign x   = op_ff[11:8];
   assign y   = op_ff[7:4];
   assign n   = op_ff[3:0];
   assign nn  = op_ff[7:0];
   assign nnn = op_ff[11:0];
   assign vx  = v_ff[x];
   assign vy  = v_ff[y];

   logic is_ret, is_call, ret_err, call_err;
   assign is_ret   = (op_ff == 16'h00EE);
   assign is_call  = (op_ff[15:12] == 4'h2);
   assign ret_err  = is_ret && (sd_ff == '0);
   assign call_err = is_call && (sd_ff == SD_W'(STACK_DEPTH));
   assign stk_we   = cmd.execute && is_call && !call_err;
   assign stk_addr = is_ret ? SP_W'(sd_ff - SD_W'(1)) : SP_W'(sd_ff);

   c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .addr    (stk_addr),
      .wr_data (pc_ff + 12'd2),
      .rd_data (stk_rd)
   );

   function automatic logic req_bit(input logic [15:0] k, input logic [3:0] s);
      return k[s];
   endfunction
   function automatic logic [7:0] req_and(input logic [7:0] a, input logic [7:0] b);
      return a & b;
   endfunction

   // Next-state values computed from the held opcode.
   logic [11:0] pc_new, idx_new;
   logic [7:0]  vx_new, vf_new;
   logic        vx_we, vf_we, err;
   logic [8:0]  sum;
   logic [11:0] pc2;
   logic        key_hit;

   always_comb begin
      pc2     = pc_ff + 12'd2;
      pc_new  = pc2;
      idx_new = idx_ff;
      vx_new  = vx;
      vf_new  = 8'd0;
      vx_we   = 1'b0;
      vf_we   = 1'b0;
      err     = ret_err || call_err;
      sum     = 9'd0;
      key_hit = req_bit(keys_ff, vx[3:0]);
      case (op_ff[15:12])
         4'h0: if (is_ret && !ret_err) pc_new = stk_rd;
         4'h1: pc_new = nnn;
         4'h2: if (!call_err) pc_new = nnn;
         4'h3: if (vx == nn) pc_new = pc_ff + 12'd4;
         4'h4: if (vx != nn) pc_new = pc_ff + 12'd4;
         4'h5: if (vx == vy) pc_new = pc_ff + 12'd4;
         4'h6: begin vx_we = 1'b1; vx_new = nn; end
         4'h7: begin vx_we = 1'b1; vx_new = vx + nn; end
         4'h8: begin
            case (n)
               4'h0: begin vx_we = 1'b1; vx_new = vy; end
               4'h1: begin vx_we = 1'b1; vx_new = vx | vy; end
               4'h2: begin vx_we = 1'b1; vx_new = vx & vy; end
               4'h3: begin vx_we = 1'b1; vx_new = vx ^ vy; end
               4'h4: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  vx_we = 1'b1; vx_new = sum[7:0];
                  vf_we = 1'b1; vf_new = {7'd0, sum[8]};
               end
               4'h5: begin
                  vx_we = 1'b1; vx_new = vx - vy;
                  vf_we = 1'b1; vf_new = {7'd0, vx >= vy};
               end
               4'h6: begin
                  vx_we = 1'b1;
                  vx_new = compat_ff ? {1'b0, vy[7:1]} : {1'b0, vx[7:1]};
                  vf_we = 1'b1; vf_new = {7'd0, compat_ff ? vy[0] : vx[0]};
               end
               4'h7: begin
                  vx_we = 1'b1; vx_new = vy - vx;
                  vf_we = 1'b1; vf_new = {7'd0, vy >= vx};
               end
               4'hE: begin
                  vx_we = 1'b1;
                  vx_new = compat_ff ? {vy[6:0], 1'b0} : {vx[6:0], 1'b0};
                  vf_we = 1'b1; vf_new = {7'd0, compat_ff ? vy[7] : vx[7]};
               end
               default: ;
            endcase
         end
         4'h9: if (vx != vy) pc_new = pc_ff + 12'd4;
         4'hA: idx_new = nnn;
         4'hC: begin vx_we = 1'b1; vx_new = req_and(rnd_ff, nn); end
         4'hE: begin
            if (nn == 8'h9E && key_hit) pc_new = pc_ff + 12'd4;
            if (nn == 8'hA1 && !key_hit) pc_new = pc_ff + 12'd4;
         end
         4'hF: begin
            case (nn)
               8'h07: begin vx_we = 1'b1; vx_new = delay_ff; end
               8'h1E: idx_new = idx_ff + {4'd0, vx};
               8'h0A: begin
                  if (kv_ff) begin vx_we = 1'b1; vx_new = {4'd0, kc_ff}; end
                  else pc_new = pc_ff;
               end
               8'h29: idx_new = font_ff + {6'd0, vx[3:0], 2'b00} + {8'd0, vx[3:0]};
               8'h55: if (compat_ff) idx_new = idx_ff + {8'd0, x} + 12'd1;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   logic is_bcd, is_store, is_clear, is_draw;
   assign is_bcd   = (op_ff[15:12] == 4'hF) && (nn == 8'h33);
   assign is_store = (op_ff[15:12] == 4'hF) && (nn == 8'h55);
   assign is_clear = (op_ff == 16'h00E0);
   assign is_draw  = (op_ff[15:12] == 4'hD);

   assign status.writes = is_bcd ? 5'd3 : (is_store ? 5'({1'b0, x} + 5'd1) : 5'd0);
   assign status.extra  = is_clear || is_draw;
   assign status.out_busy = rsp_valid && rsp_stall;

   logic [11:0] pc_eff, idx_eff;
   assign pc_eff  = pc_new;
   assign idx_eff = idx_new;

   // Fields of the result about to be loaded into the output register.
   logic [1:0]  out_kind;
   logic [11:0] out_waddr;
   logic [7:0]  out_wdata, out_dx, out_dy;
   logic [3:0]  out_rows;

   always_comb begin
      out_kind  = KIND_DONE;
      out_waddr = 12'd0;
      out_wdata = 8'd0;
      out_dx    = 8'd0;
      out_dy    = 8'd0;
      out_rows  = 4'd0;
      if (!cmd.final_out) begin
         if (is_clear) begin
            out_kind = KIND_CLEAR;
         end else if (is_draw) begin
            out_kind = KIND_DRAW;
            out_dx   = vx;
            out_dy   = vy;
            out_rows = n;
         end else begin
            out_kind  = KIND_WRITE;
            out_waddr = idx_ff + {8'd0, cmd.seq};
            out_wdata = is_bcd ? bcd_digit(vx, cmd.seq[1:0]) : v_ff[cmd.seq];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compat_ff <= 1'b0;
         font_ff   <= 12'd0;
         pc_ff     <= 12'd512;
         idx_ff    <= 12'd0;
         sd_ff     <= '0;
         delay_ff  <= 8'd0;
         sound_ff  <= 8'd0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < 16; i++) v_ff[i] <= 8'd0;
      end else begin
         if (cmd.emit) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               CSR_COMPAT: compat_ff <= csr_data[0];
               CSR_START:  pc_ff     <= csr_data;
               CSR_FONT:   font_ff   <= csr_data;
               default: ;
            endcase
         end
         if (cmd.execute) begin
            pc_ff  <= pc_new;
            idx_ff <= idx_new;
            // The flag takes priority in the if chain, so it wins over VX when X is F.
            for (int i = 0; i < 16; i++) begin
               if (vf_we && i == 15) v_ff[i] <= vf_new;
               else if (vx_we && 4'(i) == x) v_ff[i] <= vx_new;
            end
            if (op_ff[15:12] == 4'hF && nn == 8'h15) delay_ff <= vx;
            if (op_ff[15:12] == 4'hF && nn == 8'h18) sound_ff <= vx;
            if (is_ret && !ret_err) sd_ff <= sd_ff - SD_W'(1);
            if (is_call && !call_err) sd_ff <= sd_ff + SD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_instruction;
         keys_ff <= req_keys_down;
         kv_ff   <= req_key_event_valid;
         kc_ff   <= req_key_event_code;
         rnd_ff  <= req_random_byte;
      end
      if (cmd.emit) begin
         rsp_next_pc       <= pc_eff;
         rsp_index_out     <= idx_eff;
         rsp_stack_error   <= err;
         rsp_last          <= cmd.final_out;
         rsp_kind          <= out_kind;
         rsp_write_address <= out_waddr;
         rsp_write_data    <= out_wdata;
         rsp_draw_x        <= out_dx;
         rsp_draw_y        <= out_dy;
         rsp_draw_rows     <= out_rows;
      end
   end
endmodule
`default_nettype wire

>>> test/tb_chip8_instruction_execute_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chip8_instruction_execute_unit
// Drives CHIP-8 opcodes into the execute unit and checks every result
// against a behavioural model of the interpreter held in the testbench.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_execute_unit;
   import c8x_pkg::*;

   // One result item as the block presents it.
   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] waddr;
      logic [7:0]  wdata;
      logic [11:0] npc;
      logic [11:0] idx;
      logic [7:0]  dx;
      logic [7:0]  dy;
      logic [3:0]  rows;
      logic        serr;
      logic        last;
   } result_t;

   // The scoreboard holds a model of the interpreter state together with the
   // queue of results that are still owed by the block.
   class exec_scoreboard;
      logic [7:0]  v [16];
      logic [11:0] index_reg, pc, start_addr, font_addr;
      logic [11:0] stack_mem [STACK_DEPTH];
      int          depth;
      logic [7:0]  delay_t, sound_t;
      logic        compat;
      result_t     owed [$];
      int          errors;

      function void init();
         foreach (v[i]) v[i] = 8'd0;
         foreach (stack_mem[i]) stack_mem[i] = 12'd0;
         index_reg = 0; start_addr = 12'd512; pc = 12'd512; font_addr = 0;
         depth = 0; delay_t = 0; sound_t = 0; compat = 0; errors = 0;
      endfunction

      function void write_csr(logic [1:0] idx, logic [11:0] val);
         case (idx)
            CSR_COMPAT: compat = val[0];
            CSR_START: begin
               start_addr = val;
               pc = val;
            end
            CSR_FONT: font_addr = val;
            default: ;
         endcase
      endfunction

      // Note one accepted opcode and queue the results it causes.
      function void note_opcode(logic [15:0] op, logic [15:0] keys, logic kv,
                                logic [3:0] kc, logic [7:0] rnd);
         logic [3:0]  x, y, n;
         logic [7:0]  nn, vx, vy, fl;
         logic [11:0] npc;
         logic [8:0]  sum;
         logic        err;
         result_t     side [$];
         result_t     r;
         x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
         vx = v[x]; vy = v[y];
         npc = pc + 12'd2;
         err = 0;
         r = '0;
         case (op[15:12])
            4'h0: begin
               if (op == 16'h00E0) begin
                  r.kind = KIND_CLEAR; side.push_back(r);
               end else if (op == 16'h00EE) begin
                  if (depth == 0) err = 1;
                  else begin
                     depth--;
                     npc = stack_mem[depth];
                  end
               end
            end
            4'h1: npc = op[11:0];
            4'h2: begin
               if (depth >= STACK_DEPTH) err = 1;
               else begin
                  stack_mem[depth] = npc;
                  depth++;
                  npc = op[11:0];
               end
            end
            4'h3: if (vx == nn) npc += 2;
            4'h4: if (vx != nn) npc += 2;
            4'h5: if (vx == vy) npc += 2;
            4'h6: v[x] = nn;
            4'h7: v[x] = vx + nn;
            4'h8: begin
               case (n)
                  4'h0: v[x] = vy;
                  4'h1: v[x] = vx | vy;
                  4'h2: v[x] = vx & vy;
                  4'h3: v[x] = vx ^ vy;
                  4'h4: begin
                     sum = vx + vy; v[x] = sum[7:0]; v[15] = {7'd0, sum[8]};
                  end
                  4'h5: begin
                     fl = (vx >= vy); v[x] = vx - vy; v[15] = fl;
                  end
                  4'h6: begin
                     if (compat) vx = vy;
                     fl = {7'd0, vx[0]}; v[x] = vx >> 1; v[15] = fl;
                  end
                  4'h7: begin
                     fl = (vy >= vx); v[x] = vy - vx; v[15] = fl;
                  end
                  4'hE: begin
                     if (compat) vx = vy;
                     fl = {7'd0, vx[7]}; v[x] = vx << 1; v[15] = fl;
                  end
                  default: ;
               endcase
            end
            4'h9: if (vx != vy) npc += 2;
            4'hA: index_reg = op[11:0];
            4'hC: v[x] = rnd & nn;
            4'hD: begin
               r.kind = KIND_DRAW; r.dx = vx; r.dy = vy; r.rows = n;
               side.push_back(r);
            end
            4'hE: begin
               if (nn == 8'h9E && keys[vx[3:0]]) npc += 2;
               else if (nn == 8'hA1 && !keys[vx[3:0]]) npc += 2;
            end
            4'hF: begin
               case (nn)
                  8'h07: v[x] = delay_t;
                  8'h15: delay_t = vx;
                  8'h18: sound_t = vx;
                  8'h1E: index_reg = index_reg + {4'd0, vx};
                  8'h0A: if (kv) v[x] = {4'd0, kc}; else npc = pc;
                  8'h29: index_reg = font_addr + 12'd5 * {8'd0, vx[3:0]};
                  8'h33: begin
                     r.kind = KIND_WRITE;
                     r.waddr = index_reg;      r.wdata = vx / 100;
                     side.push_back(r);
                     r.waddr = index_reg + 1;  r.wdata = (vx / 10) % 10;
                     side.push_back(r);
                     r.waddr = index_reg + 2;  r.wdata = vx % 10;
                     side.push_back(r);
                  end
                  8'h55: begin
                     r.kind = KIND_WRITE;
                     for (int i = 0; i <= x; i++) begin
                        r.waddr = index_reg + i; r.wdata = v[i];
                        side.push_back(r);
                     end
                     if (compat) index_reg = index_reg + {8'd0, x} + 12'd1;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         pc = npc;
         r = '0;
         r.kind = KIND_DONE;
         side.push_back(r);
         foreach (side[i]) begin
            side[i].npc = pc; side[i].idx = index_reg; side[i].serr = err;
            side[i].last = (i == side.size() - 1);
            owed.push_back(side[i]);
         end
      endfunction

      // Compare one accepted result with the oldest owed one, field by field.
      function void check_result(result_t got);
         result_t e;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, got);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (got.kind !== e.kind) report("kind", e.kind, got.kind);
         if (got.waddr !== e.waddr) report("write_address", e.waddr, got.waddr);
         if (got.wdata !== e.wdata) report("write_data", e.wdata, got.wdata);
         if (got.npc !== e.npc) report("next_pc", e.npc, got.npc);
         if (got.idx !== e.idx) report("index_out", e.idx, got.idx);
         if (got.dx !== e.dx) report("draw_x", e.dx, got.dx);
         if (got.dy !== e.dy) report("draw_y", e.dy, got.dy);
         if (got.rows !== e.rows) report("draw_rows", e.rows, got.rows);
         if (got.serr !== e.serr) report("stack_error", e.serr, got.serr);
         if (got.last !== e.last) report("last", e.last, got.last);
      endfunction

      function void report(string f, logic [15:0] e, logic [15:0] a);
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, f, e, a);
         errors++;
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        csr_write = 0;
   logic [1:0]  csr_index = 0;
   logic [11:0] csr_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [15:0] req_instruction = 0, req_keys_down = 0;
   logic        req_key_event_valid = 0;
   logic [3:0]  req_key_event_code = 0;
   logic [7:0]  req_random_byte = 0;
   logic        rsp_valid, rsp_stall = 0;
   logic [1:0]  rsp_kind;
   logic [11:0] rsp_write_address, rsp_next_pc, rsp_index_out;
   logic [7:0]  rsp_write_data, rsp_draw_x, rsp_draw_y;
   logic [3:0]  rsp_draw_rows;
   logic        rsp_stack_error, rsp_last;

   chip8_instruction_execute_unit dut (.*);

   exec_scoreboard sb = new();
   int  cycle_count = 0;
   bit  hold_off = 0;   // long receiver hold-off requested by the stimulus
   int  sent = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Results are checked, and inputs noted, at the rising edge where the
   // transfer takes place.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && !req_stall)
         sb.note_opcode(req_instruction, req_keys_down, req_key_event_valid,
                        req_key_event_code, req_random_byte);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_kind, rsp_write_address, rsp_write_data, rsp_next_pc,
                          rsp_index_out, rsp_draw_x, rsp_draw_y, rsp_draw_rows,
                          rsp_stack_error, rsp_last});
      if (cycle_count > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver stalls on a pattern of its own: quiet stretches, random
   // stalls, and a long hold-off when the stimulus asks for one.
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else if ((cycle_count / 300) % 3 == 0) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 99) < 35);
   end

   task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
      @(negedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      sb.write_csr(idx, val);
   endtask

   // Present one opcode and hold it until the transfer has happened.
   task automatic send_op(input logic [15:0] op, input logic [15:0] keys,
                          input logic kv, input logic [3:0] kc, input logic [7:0] rnd);
      req_valid <= 1; req_instruction <= op; req_keys_down <= keys;
      req_key_event_valid <= kv; req_key_event_code <= kc; req_random_byte <= rnd;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   task automatic gap(input int n);
      req_valid <= 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_op();
      logic [15:0] op;
      logic [3:0]  hi;
      op = $urandom;
      hi = op[15:12];
      // Returns are forced on one draw in twenty, while calls come only from the
      // random opcodes, so returns outnumber calls and the stack often empties.
      case ($urandom_range(0, 19))
         0: op = 16'h00EE;
         1: op = 16'h00E0;
         2: op = {4'hF, op[11:8], 8'h33};
         3: op = {4'hF, op[11:8], 8'h55};
         4: op = {4'hF, op[11:8], 8'h1E};
         5: op = {4'hF, op[11:8], 8'h29};
         6: op = {4'hF, op[11:8], 8'h0A};
         7: op = {4'hF, op[11:8], ($urandom_range(0, 1) ? 8'h15 : 8'h07)};
         8: op = {4'hF, op[11:8], 8'h18};
         9: op = {4'hE, op[11:8], ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
         10, 11: op = {4'h8, op[11:4], 4'(($urandom_range(0, 8) == 8) ? 4'hE
                                              : $urandom_range(0, 7))};
         default: ;
      endcase
      return op;
   endfunction

   logic [15:0] directed [$];

   initial begin
      sb.init();
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed part: extremes, every operation family except 1, 7 and E, flag order with
      // X = F, stack underflow and overflow, key wait without an event.
      directed = '{16'h00EE, 16'h60FF, 16'h6101, 16'h8014, 16'h8F14, 16'h8015,
                   16'h8107, 16'h80E6, 16'h80EE, 16'h8FF6, 16'h3000, 16'h4000,
                   16'h5017, 16'h9010, 16'hAFFF, 16'hF033, 16'hFF55, 16'hF01E,
                   16'hF029, 16'hC0FF, 16'hDFFF, 16'h00E0, 16'hF00A, 16'hB123,
                   16'h0123};
      foreach (directed[i]) send_op(directed[i], 16'hFFFF, 0, 4'hF, 8'hFF);
      for (int i = 0; i < 17; i++) send_op(16'h2FFE, 16'h0000, 1, 4'h0, 8'h00);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_COMPAT, 12'd1); write_reg(CSR_START, 12'hFFE);
               write_reg(CSR_FONT, 12'hFFF);
            end
            1: begin
               write_reg(CSR_COMPAT, 12'd0); write_reg(CSR_START, 12'h000);
               write_reg(CSR_FONT, 12'h000);
            end
            2: begin
               write_reg(CSR_COMPAT, 12'($urandom_range(0, 1)));
               write_reg(CSR_START, 12'($urandom));
               write_reg(CSR_FONT, 12'($urandom));
            end
            default: write_reg(CSR_COMPAT, 12'd1);
         endcase
         for (int j = 0; j < 84; j++) begin
            // The long hold-off falls in the second phase while items keep
            // being offered.
            if (phase == 1 && j == 10) fork
               begin
                  hold_off = 1;
                  repeat (200) @(negedge clock);
                  hold_off = 0;
               end
            join_none
            send_op(rand_op(), 16'($urandom), 1'($urandom), 4'($urandom),
                    8'($urandom));
            if ($urandom_range(0, 3) == 0) gap($urandom_range(1, 6));
         end
         drain();
      end

      if (sb.errors == 0 && sb.owed.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

>>> sim.f
hdl/c8x_pkg.sv
hdl/c8x_ram.sv
hdl/c8x_ctrl.sv
hdl/c8x_datapath.sv
hdl/chip8_instruction_execute_unit.sv
test/tb_chip8_instruction_execute_unit.sv
